// ===== src/icd_pkg.sv =====
// Shared types and constants for the input chord detector.
// Used by icd_ctrl, icd_datapath and input_chord_detector_unit; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package icd_pkg;

    // Default number of held entries.
    localparam int ICD_COMBO_DEPTH = 8;

    // Configuration port geometry and register map.
    localparam int          APB_ADDR_W       = 2;
    localparam int          APB_DATA_W       = 32;
    localparam logic [1:0]  ADDR_TIMEOUT     = 2'd0;
    localparam logic [15:0] TIMEOUT_RESET_MS = 16'd80;

    // Field codes.
    localparam logic       OP_PRESS    = 1'b0;
    localparam logic       OP_RELEASE  = 1'b1;
    localparam logic [1:0] KIND_BUTTON = 2'd0;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // One held primitive.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] index;
        logic [1:0] dir;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;     // latch the accepted word, rewind the scan pointers
        logic compact_step;  // copy one surviving entry down
        logic compact_done;  // adopt the compacted count
        logic press_eval;    // apply the timeout, prepare a drop sweep
        logic drop_step;     // shift one entry towards the head
        logic drop_done;     // forget the oldest entry
        logic append;        // store the new press
        logic sel_out;       // read port serves the output
        logic emit_adv;      // step to the next entry of the combo
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_void;       // offered word has the unused kind
        logic is_release;    // latched word is a release
        logic scan_done;     // read pointer has reached the count
        logic will_drop;     // list is full once the timeout is applied
        logic has_entries;   // at least one entry is held
        logic emit_last;     // output pointer is on the final entry
    } sts_t;

endpackage

`default_nettype wire

// ===== src/icd_ctrl.sv =====
// Sequencing state machine for the input chord detector.
// Depends on icd_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module icd_ctrl
    import icd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  wire logic out_stall,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_PRESS  = 3'd2;
    localparam logic [2:0] S_DROP   = 3'd3;
    localparam logic [2:0] S_APPEND = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                // A word of the unused kind is taken and has no effect.
                if (in_valid && !sts.in_void)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!sts.scan_done)
                begin
                    cmd.compact_step = 1'b1;
                end
                else
                begin
                    cmd.compact_done = 1'b1;
                    state_next = sts.is_release ? S_IDLE : S_PRESS;
                end
            end
            S_PRESS:
            begin
                cmd.press_eval = 1'b1;
                state_next = sts.will_drop ? S_DROP : S_APPEND;
            end
            S_DROP:
            begin
                if (!sts.scan_done)
                begin
                    cmd.drop_step = 1'b1;
                end
                else
                begin
                    cmd.drop_done = 1'b1;
                    state_next    = S_APPEND;
                end
            end
            S_APPEND:
            begin
                cmd.append = 1'b1;
                // An earlier entry plus this one makes a combo.
                state_next = sts.has_entries ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                out_valid   = 1'b1;
                cmd.sel_out = 1'b1;
                if (!out_stall)
                begin
                    cmd.emit_adv = 1'b1;
                    if (sts.emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/icd_datapath.sv =====
// Entry store, pointers, timeout compare and output selection for the chord detector.
// Depends on icd_pkg; driven by icd_ctrl through cmd_t and answers with sts_t.
`timescale 1ns / 1ps
`default_nettype none

module icd_datapath
    import icd_pkg::*;
#(
    parameter int COMBO_DEPTH = ICD_COMBO_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cmd_t        cmd,
    output sts_t             sts,
    input  wire logic [15:0] timeout_ms,
    input  wire logic        opcode,
    input  wire logic [1:0]  control_kind,
    input  wire logic [7:0]  control_index,
    input  wire logic [1:0]  direction,
    input  wire logic [31:0] time_ms,
    output logic [1:0]       entry_kind,
    output logic [7:0]       entry_index,
    output logic [1:0]       entry_direction,
    output logic             last_entry
);

    localparam int CW = $clog2(COMBO_DEPTH + 1);
    localparam int IW = $clog2(COMBO_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(COMBO_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    entry_t        entries [COMBO_DEPTH];
    logic          op_reg;
    entry_t        item_reg;
    logic [31:0]   time_reg;
    logic [31:0]   last_time_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] rd_ptr_reg;
    logic [CW-1:0] wr_ptr_reg;
    logic [CW-1:0] out_ptr_reg;

    logic [CW-1:0] rd_addr;
    entry_t        rd_entry;
    logic          match;
    logic [31:0]   elapsed;
    logic          expired;
    logic [CW-1:0] eff_count;
    logic [CW-1:0] drop_addr;
    logic          wr_en;
    logic [IW-1:0] wr_idx;
    entry_t        wr_data;

    // Single read port, shared between the sweeps and the output.
    assign rd_addr  = cmd.sel_out ? out_ptr_reg : rd_ptr_reg;
    assign rd_entry = entries[rd_addr[IW-1:0]];
    assign match    = (rd_entry.kind == item_reg.kind) && (rd_entry.index == item_reg.index);

    assign elapsed   = time_reg - last_time_reg;
    assign expired   = elapsed > {16'd0, timeout_ms};
    assign eff_count = expired ? '0 : count_reg;
    assign drop_addr = rd_ptr_reg - ONE_C;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_idx  = wr_ptr_reg[IW-1:0];
        wr_data = rd_entry;
        if (cmd.compact_step && !match)
        begin
            wr_en = 1'b1;
        end
        if (cmd.drop_step)
        begin
            wr_en  = 1'b1;
            wr_idx = drop_addr[IW-1:0];
        end
        if (cmd.append)
        begin
            wr_en   = 1'b1;
            wr_idx  = count_reg[IW-1:0];
            wr_data = item_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entries[wr_idx] <= wr_data;
        end
        if (cmd.load_item)
        begin
            op_reg         <= opcode;
            item_reg.kind  <= control_kind;
            item_reg.index <= control_index;
            item_reg.dir   <= (control_kind == KIND_BUTTON) ? 2'd0 : direction;
            time_reg       <= time_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            last_time_reg <= '0;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            out_ptr_reg   <= '0;
        end
        else
        begin
            if (cmd.load_item)
            begin
                rd_ptr_reg <= '0;
                wr_ptr_reg <= '0;
            end
            if (cmd.compact_step)
            begin
                rd_ptr_reg <= rd_ptr_reg + ONE_C;
                if (!match)
                begin
                    wr_ptr_reg <= wr_ptr_reg + ONE_C;
                end
            end
            if (cmd.compact_done)
            begin
                count_reg <= wr_ptr_reg;
            end
            if (cmd.press_eval)
            begin
                count_reg  <= eff_count;
                rd_ptr_reg <= ONE_C;
            end
            if (cmd.drop_step)
            begin
                rd_ptr_reg <= rd_ptr_reg + ONE_C;
            end
            if (cmd.drop_done)
            begin
                count_reg <= count_reg - ONE_C;
            end
            if (cmd.append)
            begin
                count_reg     <= count_reg + ONE_C;
                last_time_reg <= time_reg;
                out_ptr_reg   <= '0;
            end
            if (cmd.emit_adv)
            begin
                out_ptr_reg <= out_ptr_reg + ONE_C;
            end
        end
    end

    always_comb
    begin
        sts.in_void     = (control_kind == KIND_UNUSED);
        sts.is_release  = (op_reg == OP_RELEASE);
        sts.scan_done   = (rd_ptr_reg == count_reg);
        sts.will_drop   = (eff_count == DEPTH_C);
        sts.has_entries = (count_reg != '0);
        sts.emit_last   = (out_ptr_reg == count_reg - ONE_C);
    end

    assign entry_kind      = rd_entry.kind;
    assign entry_index     = rd_entry.index;
    assign entry_direction = rd_entry.dir;
    assign last_entry      = sts.emit_last;

    // The held count never exceeds the store.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("held count exceeds the store depth");

    // Compaction never writes ahead of where it reads.
    a_wr_behind_rd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.compact_step |-> wr_ptr_reg <= rd_ptr_reg)
        else $error("compaction write pointer passed the read pointer");

    // Output reads only held entries.
    a_out_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sel_out |-> out_ptr_reg < count_reg)
        else $error("output pointer beyond the held entries");

    // An append always leaves something held.
    a_append_holds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |=> count_reg != '0)
        else $error("append left the list empty");

endmodule

`default_nettype wire

// ===== src/input_chord_detector_unit.sv =====
// Top level of the input chord detector: configuration register, controller and datapath.
// Depends on icd_pkg, icd_ctrl and icd_datapath.
//
// Use of the block:
// Each input word (in_valid / in_stall) is a press or release of one control. The block
// keeps the list of held controls and, after a press that leaves two or more held, sends
// the whole list oldest first as output words (out_valid / out_stall), last_entry marking
// the final one. A word is taken when valid is high and stall is low.
// One word is handled at a time. Once a word is accepted, the held entries are compacted
// through the single read port of the entry store, dropping any that match its control;
// a release ends there. A press then applies the timeout compare, shifts out the oldest
// entry when the list is full after the timeout, appends the new entry, and sends the
// combo when one is formed.
// The output payload is read straight from the entry store and holds while out_stall is
// high; no new input word is taken until the last output word has gone.
// Reset clears the list, the previous press time and the state machine, and sets the
// timeout register (byte address 0 of the APB-style port) to 80 ms. The register should
// only be written while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module input_chord_detector_unit
    import icd_pkg::*;
#(
    parameter int COMBO_DEPTH = ICD_COMBO_DEPTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Configuration port.
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    // Input channel.
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  opcode,
    input  wire logic [1:0]            control_kind,
    input  wire logic [7:0]            control_index,
    input  wire logic [1:0]            direction,
    input  wire logic [31:0]           time_ms,
    // Output channel.
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [1:0]                 entry_kind,
    output logic [7:0]                 entry_index,
    output logic [1:0]                 entry_direction,
    output logic                       last_entry
);

    logic [15:0] timeout_reg;
    logic [15:0] timeout_next;
    logic        cfg_write;
    cmd_t        cmd;
    sts_t        sts;

    // The port never inserts wait states.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_TIMEOUT);

    // Only the low half of the data word is kept; the timeout is 16 bits wide.
    assign timeout_next = cfg_write ? pwdata[15:0] : timeout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET_MS;
        end
        else
        begin
            timeout_reg <= timeout_next;
        end
    end

    // Reads of unmapped addresses return zero.
    assign prdata = (paddr == ADDR_TIMEOUT) ? {{(APB_DATA_W-16){1'b0}}, timeout_reg} : '0;

    icd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    icd_datapath #(
        .COMBO_DEPTH (COMBO_DEPTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .timeout_ms      (timeout_reg),
        .opcode          (opcode),
        .control_kind    (control_kind),
        .control_index   (control_index),
        .direction       (direction),
        .time_ms         (time_ms),
        .entry_kind      (entry_kind),
        .entry_index     (entry_index),
        .entry_direction (entry_direction),
        .last_entry      (last_entry)
    );

endmodule

`default_nettype wire
